[rtl/midpoint_circle_rasterizer_unit_macros.svh]
// assertion macros for the midpoint circle rasterizer checker
// expects clk and rst_n in the scope of each use
`ifndef MIDPOINT_CIRCLE_RASTERIZER_UNIT_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define MCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mcr_pkg.sv]
// shared constants for the midpoint circle rasterizer
// no dependencies
`timescale 1ns / 1ps

package mcr_pkg;

  // default field widths
  localparam int COORD_BITS_DEF  = 10;
  localparam int RADIUS_BITS_DEF = 9;

  // group queue depth, power of two
  localparam int Q_DEPTH = 2;

  // command codes carried on in_tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // octant index of the final point of each group
  localparam logic [2:0] OCT_LAST = 3'd7;

endpackage

[rtl/midpoint_circle_rasterizer_unit.sv]
// channel   dir  payload                                      marker
// in_*      in   tdata: center_x, center_y, radius            tuser: command (0 start, 1 tick)
// out_*     out  tdata: point_x, point_y, octant              tlast: last, tuser: circle_done
//
// a start, or a tick while a circle is active, gives eight points, one per cycle while out_tready is
// high, from the back end's point generator; a new command can be taken before those points are out
// first point goes through the group queue and the output register; a tick while idle gives no points
// reset (rst_n low, synchronous) clears the circle state, the group queue and the output valid
// out_tready low holds the current point; the queue keeps two groups so commands keep coming
// top level of the midpoint circle rasterizer; uses mcr_pkg, mcr_front, mcr_queue, mcr_back
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_unit
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int IN_W        = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8,
  parameter int OUT_W       = ((2 * (COORD_BITS + 2) + 3 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // center_x, center_y, radius, zero fill
  input  logic             in_tuser,   // command
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // point_x, point_y, octant, zero fill
  output logic             out_tlast,
  output logic             out_tuser   // circle_done
);

  localparam int GRP_W    = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;
  localparam int OUT_BITS = COORD_BITS + 2;

  logic             fq_valid, fq_ready;
  logic [GRP_W-1:0] fq_data;
  logic             qb_valid, qb_ready;
  logic [GRP_W-1:0] qb_data;

  logic signed [OUT_BITS-1:0] pt_x, pt_y;
  logic [2:0]                 pt_oct;

  // command intake and stepping
  mcr_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .GRP_W       (GRP_W),
    .IN_W        (IN_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .grp_valid (fq_valid),
    .grp_ready (fq_ready),
    .grp_data  (fq_data)
  );

  // group queue
  mcr_queue #(
    .WIDTH (GRP_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // point generation
  mcr_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .GRP_W       (GRP_W),
    .OUT_BITS    (OUT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (qb_valid),
    .grp_ready (qb_ready),
    .grp_data  (qb_data),
    .pt_valid  (out_tvalid),
    .pt_ready  (out_tready),
    .pt_x      (pt_x),
    .pt_y      (pt_y),
    .pt_oct    (pt_oct),
    .pt_last   (out_tlast),
    .pt_done   (out_tuser)
  );

  // result packing
  assign out_tdata = OUT_W'({pt_oct, pt_y, pt_x});

endmodule

[rtl/mcr_front.sv]
// front end: takes commands, holds the circle state, runs one midpoint step per
// active tick and pushes a group for each start or active tick; uses mcr_pkg
`timescale 1ns / 1ps

module mcr_front
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int GRP_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 1,
  parameter int IN_W        = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tuser,
  output logic             grp_valid,
  input  logic             grp_ready,
  output logic [GRP_W-1:0] grp_data
);

  localparam int DEC_BITS = RADIUS_BITS + 3;

  logic                   act_r, act_nxt;
  logic [COORD_BITS-1:0]  cx_r, cx_nxt;
  logic [COORD_BITS-1:0]  cy_r, cy_nxt;
  logic [RADIUS_BITS-1:0] xo_r, xo_nxt;
  logic [RADIUS_BITS-1:0] yo_r, yo_nxt;
  logic [DEC_BITS-1:0]    dec_r, dec_nxt;

  logic                   is_start;
  logic                   accept;
  logic                   dec_neg;
  logic [RADIUS_BITS-1:0] x_inc;
  logic [RADIUS_BITS-1:0] y_dec;
  logic [DEC_BITS-1:0]    dec_add;
  logic                   done;

  assign is_start  = (in_tuser == CMD_START);
  assign in_tready = grp_ready;
  assign accept    = in_tvalid && in_tready;
  assign grp_valid = in_tvalid && (is_start || act_r);

  // one midpoint step
  assign dec_neg = dec_r[DEC_BITS-1];
  assign x_inc   = xo_r + 1'b1;
  assign y_dec   = yo_r - 1'b1;
  assign dec_add = dec_neg
                   ? ((DEC_BITS'(x_inc) << 1) + DEC_BITS'(1))
                   : (((DEC_BITS'(x_inc) - DEC_BITS'(y_dec)) << 1) + DEC_BITS'(1));

  // next state for start and tick
  always_comb begin
    act_nxt = act_r;
    cx_nxt  = cx_r;
    cy_nxt  = cy_r;
    xo_nxt  = xo_r;
    yo_nxt  = yo_r;
    dec_nxt = dec_r;
    if (is_start) begin
      cx_nxt  = in_tdata[COORD_BITS-1:0];
      cy_nxt  = in_tdata[2*COORD_BITS-1:COORD_BITS];
      xo_nxt  = '0;
      yo_nxt  = in_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
      dec_nxt = DEC_BITS'(1) - DEC_BITS'(yo_nxt);
    end else if (act_r) begin
      xo_nxt  = x_inc;
      yo_nxt  = dec_neg ? yo_r : y_dec;
      dec_nxt = dec_r + dec_add;
    end
    done = (xo_nxt >= yo_nxt);
    if (is_start || act_r) begin
      act_nxt = !done;
    end
  end

  // descriptor of the group to emit
  assign grp_data = {done, yo_nxt, xo_nxt, cy_nxt, cx_nxt};

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cx_r  <= '0;
      cy_r  <= '0;
      xo_r  <= '0;
      yo_r  <= '0;
      dec_r <= '0;
    end else if (accept) begin
      act_r <= act_nxt;
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      xo_r  <= xo_nxt;
      yo_r  <= yo_nxt;
      dec_r <= dec_nxt;
    end
  end

endmodule

[rtl/mcr_queue.sv]
// short queue of group descriptors between front and back end
// uses mcr_pkg for the depth
`timescale 1ns / 1ps

module mcr_queue
  import mcr_pkg::*;
#(
  parameter int WIDTH = 39
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers wrap naturally since the depth is a power of two
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/mcr_back.sv]
// back end: expands each group descriptor into eight points, one per cycle
// while pt_ready is high, into an output register; uses mcr_pkg
`timescale 1ns / 1ps

module mcr_back
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int GRP_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 1,
  parameter int OUT_BITS    = COORD_BITS + 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       grp_valid,
  output logic                       grp_ready,
  input  logic [GRP_W-1:0]           grp_data,
  output logic                       pt_valid,
  input  logic                       pt_ready,
  output logic signed [OUT_BITS-1:0] pt_x,
  output logic signed [OUT_BITS-1:0] pt_y,
  output logic [2:0]                 pt_oct,
  output logic                       pt_last,
  output logic                       pt_done
);

  logic [COORD_BITS-1:0]  g_cx, g_cy;
  logic [RADIUS_BITS-1:0] g_x, g_y;
  logic                   g_done;
  logic [OUT_BITS-1:0]    cxo, cyo, u, v;
  logic                   load;

  logic                       val_r, val_nxt;
  logic [2:0]                 cnt_r, cnt_nxt;
  logic signed [OUT_BITS-1:0] px_r, py_r;
  logic [2:0]                 oct_r;
  logic                       last_r, done_r;

  assign {g_done, g_y, g_x, g_cy, g_cx} = grp_data;

  // load a new point when the output register is free or being taken
  assign load      = grp_valid && (!val_r || pt_ready);
  assign grp_ready = load && (cnt_r == OCT_LAST);

  // octant bit 2 swaps the offsets, bit 0 negates x, bit 1 negates y
  assign cxo = OUT_BITS'(g_cx);
  assign cyo = OUT_BITS'(g_cy);
  assign u   = cnt_r[2] ? OUT_BITS'(g_y) : OUT_BITS'(g_x);
  assign v   = cnt_r[2] ? OUT_BITS'(g_x) : OUT_BITS'(g_y);

  always_comb begin
    cnt_nxt = load ? cnt_r + 1'b1 : cnt_r;
    val_nxt = load ? 1'b1 : (pt_ready ? 1'b0 : val_r);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      val_r <= val_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // point payload
  always_ff @(posedge clk) begin
    if (load) begin
      px_r   <= cnt_r[0] ? (cxo - u) : (cxo + u);
      py_r   <= cnt_r[1] ? (cyo - v) : (cyo + v);
      oct_r  <= cnt_r;
      last_r <= (cnt_r == OCT_LAST);
      done_r <= (cnt_r == OCT_LAST) && g_done;
    end
  end

  assign pt_valid = val_r;
  assign pt_x     = px_r;
  assign pt_y     = py_r;
  assign pt_oct   = oct_r;
  assign pt_last  = last_r;
  assign pt_done  = done_r;

endmodule

[rtl/mcr_checker.sv]
// port-level checker for the midpoint circle rasterizer, bound to the top level
// uses mcr_pkg and the assertion macros header
`timescale 1ns / 1ps
`include "midpoint_circle_rasterizer_unit_macros.svh"

module mcr_checker
  import mcr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int OUT_W      = ((2 * (COORD_BITS + 2) + 3 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast,
  input logic             out_tuser
);

  localparam int OCT_LO = 2 * (COORD_BITS + 2);

  logic [2:0] oct;
  assign oct = out_tdata[OCT_LO+2:OCT_LO];

  // tlast marks the eighth point of a group
  `MCR_ASSERT_NOW(a_last_oct, out_tvalid, out_tlast == (oct == OCT_LAST), "tlast off octant 7")

  // circle done only on a group's last point
  `MCR_ASSERT_NOW(a_done_last, out_tvalid && out_tuser, out_tlast, "circle_done without tlast")

  // points of a group follow without gaps, octant counting up
  `MCR_ASSERT_NEXT(a_oct_seq, out_tvalid && out_tready && !out_tlast,
                   out_tvalid && (oct == $past(oct) + 3'd1), "group broken or octant skipped")

  // a stalled point holds
  `MCR_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled point changed")

endmodule

bind midpoint_circle_rasterizer_unit mcr_checker #(
  .COORD_BITS (COORD_BITS),
  .OUT_W      (OUT_W)
) u_mcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
